>>> rtl/core/iie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iie_pkg;

   localparam int STACK_DEPTH    = 16;
   localparam int VALUE_WIDTH    = 32;
   localparam int CNT_WIDTH      = $clog2(STACK_DEPTH + 1);
   localparam int IDX_WIDTH      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TOKQ_DEPTH     = 4;
   localparam int TOKQ_IDX_WIDTH = $clog2(TOKQ_DEPTH);
   localparam int TOKQ_CNT_WIDTH = $clog2(TOKQ_DEPTH + 1);
   localparam int DIV_CNT_WIDTH  = $clog2(VALUE_WIDTH);

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ADD    = 8'h2B;
   localparam logic [7:0] CH_SUB    = 8'h2D;
   localparam logic [7:0] CH_MUL    = 8'h2A;
   localparam logic [7:0] CH_DIV    = 8'h2F;
   localparam logic [7:0] CH_MOD    = 8'h25;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef enum logic [2:0] {
      OPC_LPAREN = 3'd1,
      OPC_ADD    = 3'd2,
      OPC_SUB    = 3'd3,
      OPC_MUL    = 3'd4,
      OPC_DIV    = 3'd5,
      OPC_MOD    = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIVZERO  = 2'd1,
      ST_PAREN    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      TK_NONE  = 3'd0,
      TK_DIGIT = 3'd1,
      TK_OPEN  = 3'd2,
      TK_CLOSE = 3'd3,
      TK_OP    = 3'd4
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [3:0]     digit;
      opcode_type     op;
      logic           last;
   } token_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0] opnd_cnt;
      logic [CNT_WIDTH-1:0] oper_cnt;
   } back_status_type;

   function automatic logic [1:0] prec(input opcode_type op);
      logic [1:0] p;
      case (op)
         OPC_ADD, OPC_SUB:          p = 2'd1;
         OPC_MUL, OPC_DIV, OPC_MOD: p = 2'd2;
         default:                   p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/iie_front.sv
`timescale 1ns / 1ps
`default_nettype none

// character classifier
module iie_front (
   input  iie_pkg::req_type   req_in,
   output iie_pkg::token_type tok_out
);

   always_comb begin
      tok_out.kind  = iie_pkg::TK_NONE;
      tok_out.digit = 4'(req_in.char_code - iie_pkg::CH_ZERO);
      tok_out.op    = iie_pkg::OPC_ADD;
      tok_out.last  = req_in.last;
      if (req_in.char_code >= iie_pkg::CH_ZERO && req_in.char_code <= iie_pkg::CH_NINE) begin
         tok_out.kind = iie_pkg::TK_DIGIT;
      end else begin
         case (req_in.char_code)
            iie_pkg::CH_LPAREN: tok_out.kind = iie_pkg::TK_OPEN;
            iie_pkg::CH_RPAREN: tok_out.kind = iie_pkg::TK_CLOSE;
            iie_pkg::CH_ADD: begin
               tok_out.kind = iie_pkg::TK_OP;
               tok_out.op   = iie_pkg::OPC_ADD;
            end
            iie_pkg::CH_SUB: begin
               tok_out.kind = iie_pkg::TK_OP;
               tok_out.op   = iie_pkg::OPC_SUB;
            end
            iie_pkg::CH_MUL: begin
               tok_out.kind = iie_pkg::TK_OP;
               tok_out.op   = iie_pkg::OPC_MUL;
            end
            iie_pkg::CH_DIV: begin
               tok_out.kind = iie_pkg::TK_OP;
               tok_out.op   = iie_pkg::OPC_DIV;
            end
            iie_pkg::CH_MOD: begin
               tok_out.kind = iie_pkg::TK_OP;
               tok_out.op   = iie_pkg::OPC_MOD;
            end
            default: tok_out.kind = iie_pkg::TK_NONE;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/iie_tokq.sv
`timescale 1ns / 1ps
`default_nettype none

// small token queue between classifier and executor
module iie_tokq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  iie_pkg::token_type push_data,
   output logic               full,
   input  logic               pop,
   output iie_pkg::token_type pop_data,
   output logic               empty
);

   iie_pkg::token_type                   entry_ff [iie_pkg::TOKQ_DEPTH];
   logic [iie_pkg::TOKQ_IDX_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [iie_pkg::TOKQ_IDX_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [iie_pkg::TOKQ_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                                 do_push, do_pop;

   assign full     = (cnt_ff == iie_pkg::TOKQ_CNT_WIDTH'(iie_pkg::TOKQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/iie_back.sv
`timescale 1ns / 1ps
`default_nettype none

// token executor: operand/operator stacks, ALU, iterative divider
module iie_back (
   input  logic                     clock,
   input  logic                     reset,
   input  iie_pkg::token_type       tok,
   input  logic                     tok_empty,
   output logic                     tok_pop,
   output iie_pkg::rsp_type         rsp_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output iie_pkg::back_status_type status
);

   localparam int W  = iie_pkg::VALUE_WIDTH;
   localparam int CW = iie_pkg::CNT_WIDTH;
   localparam int IW = iie_pkg::IDX_WIDTH;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_WAIT   = 6'b000010,
      S_LOOP   = 6'b000100,
      S_EXEC   = 6'b001000,
      S_DIV    = 6'b010000,
      S_DIVEND = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      MODE_OP    = 2'd0,
      MODE_CLOSE = 2'd1,
      MODE_END   = 2'd2
   } mode_type;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   iie_pkg::opcode_type    pend_ff, pend_in;
   iie_pkg::opcode_type    op_ff, op_in;
   logic                   last_ff, last_in;
   iie_pkg::value_type     acc_ff, acc_in;
   logic                   in_num_ff, in_num_in;
   iie_pkg::status_type    err_ff, err_in;
   logic [CW-1:0]          opnd_cnt_ff, opnd_cnt_in;
   logic [CW-1:0]          oper_cnt_ff, oper_cnt_in;
   iie_pkg::value_type     a_ff, a_in, b_ff, b_in;
   iie_pkg::value_type     rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [iie_pkg::DIV_CNT_WIDTH-1:0] dcnt_ff, dcnt_in;
   logic                   neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic                   out_valid_ff, out_valid_in;
   iie_pkg::rsp_type       out_ff, out_in;

   iie_pkg::value_type     opnd_mem [iie_pkg::STACK_DEPTH];
   iie_pkg::value_type     rd_top_ff, rd_sub_ff;
   iie_pkg::opcode_type    oper_stk_ff [iie_pkg::STACK_DEPTH];

   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   iie_pkg::value_type     wr_data;
   logic                   op_wr_en;
   logic [IW-1:0]          op_wr_addr;
   iie_pkg::opcode_type    op_wr_data;

   logic [CW-1:0]          opnd_m1, opnd_m2, oper_m1;
   iie_pkg::opcode_type    top_op;
   logic                   has_op;
   iie_pkg::value_type     acc_dig, ma, mb, alu_res, div_res;
   logic [W:0]             shifted;
   logic                   ge;
   logic                   opnd_full, oper_full;

   assign opnd_m1   = opnd_cnt_ff - CW'(1);
   assign opnd_m2   = opnd_cnt_ff - CW'(2);
   assign oper_m1   = oper_cnt_ff - CW'(1);
   assign top_op    = oper_stk_ff[oper_m1[IW-1:0]];
   assign has_op    = (oper_cnt_ff != '0);
   assign opnd_full = (opnd_cnt_ff >= CW'(iie_pkg::STACK_DEPTH));
   assign oper_full = (oper_cnt_ff >= CW'(iie_pkg::STACK_DEPTH));
   assign acc_dig   = (acc_ff << 3) + (acc_ff << 1) + W'(tok.digit);
   assign ma        = a_ff[W-1] ? (~a_ff + 1'b1) : a_ff;
   assign mb        = b_ff[W-1] ? (~b_ff + 1'b1) : b_ff;
   assign shifted   = {rem_ff, quo_ff[W-1]};
   assign ge        = (shifted >= {1'b0, dvs_ff});

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;
   assign status.opnd_cnt = opnd_cnt_ff;
   assign status.oper_cnt = oper_cnt_ff;

   always_comb begin
      case (op_ff)
         iie_pkg::OPC_ADD: alu_res = a_ff + b_ff;
         iie_pkg::OPC_SUB: alu_res = a_ff - b_ff;
         iie_pkg::OPC_MUL: alu_res = W'(a_ff * b_ff);
         default:          alu_res = '0;
      endcase
      if (op_ff == iie_pkg::OPC_DIV) begin
         div_res = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
      end else begin
         div_res = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      in_num_in    = in_num_ff;
      err_in       = err_ff;
      opnd_cnt_in  = opnd_cnt_ff;
      oper_cnt_in  = oper_cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      dcnt_in      = dcnt_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      tok_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = opnd_cnt_ff[IW-1:0];
      wr_data      = acc_ff;
      op_wr_en     = 1'b0;
      op_wr_addr   = oper_cnt_ff[IW-1:0];
      op_wr_data   = iie_pkg::OPC_LPAREN;

      case (state_ff)
         S_IDLE: begin
            if (!tok_empty) begin
               tok_pop = 1'b1;
               last_in = tok.last;
               if (err_ff != iie_pkg::ST_OK) begin
                  if (tok.last) begin
                     mode_in  = MODE_END;
                     state_in = S_WAIT;
                  end
               end else if (tok.kind == iie_pkg::TK_DIGIT) begin
                  if (tok.last) begin
                     if (opnd_full) begin
                        err_in = iie_pkg::ST_OVERFLOW;
                     end else begin
                        wr_en       = 1'b1;
                        wr_data     = acc_dig;
                        opnd_cnt_in = opnd_cnt_ff + 1'b1;
                     end
                     acc_in    = '0;
                     in_num_in = 1'b0;
                     mode_in   = MODE_END;
                     state_in  = S_WAIT;
                  end else begin
                     acc_in    = acc_dig;
                     in_num_in = 1'b1;
                  end
               end else begin
                  // flush a pending number first
                  if (in_num_ff) begin
                     if (opnd_full) begin
                        err_in = iie_pkg::ST_OVERFLOW;
                     end else begin
                        wr_en       = 1'b1;
                        opnd_cnt_in = opnd_cnt_ff + 1'b1;
                     end
                     acc_in    = '0;
                     in_num_in = 1'b0;
                  end
                  if (in_num_ff && opnd_full) begin
                     if (tok.last) begin
                        mode_in  = MODE_END;
                        state_in = S_WAIT;
                     end
                  end else begin
                     case (tok.kind)
                        iie_pkg::TK_OPEN: begin
                           if (oper_full) begin
                              err_in = iie_pkg::ST_OVERFLOW;
                           end else begin
                              op_wr_en    = 1'b1;
                              oper_cnt_in = oper_cnt_ff + 1'b1;
                           end
                           if (tok.last) begin
                              mode_in  = MODE_END;
                              state_in = S_WAIT;
                           end
                        end
                        iie_pkg::TK_CLOSE: begin
                           mode_in  = MODE_CLOSE;
                           state_in = S_WAIT;
                        end
                        iie_pkg::TK_OP: begin
                           mode_in  = MODE_OP;
                           pend_in  = tok.op;
                           state_in = S_WAIT;
                        end
                        default: begin
                           if (tok.last) begin
                              mode_in  = MODE_END;
                              state_in = S_WAIT;
                           end
                        end
                     endcase
                  end
               end
            end
         end

         // stack read data lands after this cycle
         S_WAIT: state_in = S_LOOP;

         S_LOOP: begin
            if (err_ff != iie_pkg::ST_OK && mode_ff != MODE_END) begin
               if (last_ff) mode_in = MODE_END;
               else state_in = S_IDLE;
            end else begin
               logic do_red;
               logic done_tok;
               logic emit;
               do_red   = 1'b0;
               done_tok = 1'b0;
               emit     = 1'b0;
               case (mode_ff)
                  MODE_OP: begin
                     if (has_op && iie_pkg::prec(top_op) >= iie_pkg::prec(pend_ff)) begin
                        do_red = 1'b1;
                     end else begin
                        if (oper_full) begin
                           err_in = iie_pkg::ST_OVERFLOW;
                        end else begin
                           op_wr_en    = 1'b1;
                           op_wr_data  = pend_ff;
                           oper_cnt_in = oper_cnt_ff + 1'b1;
                        end
                        done_tok = 1'b1;
                     end
                  end
                  MODE_CLOSE: begin
                     if (has_op && top_op != iie_pkg::OPC_LPAREN) begin
                        do_red = 1'b1;
                     end else begin
                        if (!has_op) err_in = iie_pkg::ST_PAREN;
                        else oper_cnt_in = oper_m1;
                        done_tok = 1'b1;
                     end
                  end
                  default: begin
                     if (err_ff != iie_pkg::ST_OK || !has_op) begin
                        emit = 1'b1;
                     end else if (top_op == iie_pkg::OPC_LPAREN) begin
                        err_in = iie_pkg::ST_PAREN;
                     end else begin
                        do_red = 1'b1;
                     end
                  end
               endcase
               if (do_red) begin
                  op_in       = top_op;
                  oper_cnt_in = oper_m1;
                  b_in        = (opnd_cnt_ff >= CW'(1)) ? rd_top_ff : '0;
                  a_in        = (opnd_cnt_ff >= CW'(2)) ? rd_sub_ff : '0;
                  opnd_cnt_in = (opnd_cnt_ff >= CW'(2)) ? opnd_m2 : '0;
                  state_in    = S_EXEC;
               end
               if (done_tok) begin
                  if (last_ff) begin
                     mode_in  = MODE_END;
                     state_in = S_WAIT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               if (emit && (!out_valid_ff || rsp_pop)) begin
                  out_valid_in  = 1'b1;
                  out_in.status = err_ff;
                  out_in.value  = (err_ff == iie_pkg::ST_OK && opnd_cnt_ff != '0) ?
                                  32'(rd_top_ff) : '0;
                  opnd_cnt_in   = '0;
                  oper_cnt_in   = '0;
                  acc_in        = '0;
                  in_num_in     = 1'b0;
                  err_in        = iie_pkg::ST_OK;
                  state_in      = S_IDLE;
               end
            end
         end

         S_EXEC: begin
            if (op_ff == iie_pkg::OPC_DIV || op_ff == iie_pkg::OPC_MOD) begin
               if (mb == '0) begin
                  err_in = iie_pkg::ST_DIVZERO;
                  if (last_ff) begin
                     mode_in  = MODE_END;
                     state_in = S_WAIT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  rem_in   = '0;
                  quo_in   = ma;
                  dvs_in   = mb;
                  dcnt_in  = '0;
                  neg_q_in = a_ff[W-1] ^ b_ff[W-1];
                  neg_r_in = a_ff[W-1];
                  state_in = S_DIV;
               end
            end else begin
               if (opnd_full) begin
                  err_in = iie_pkg::ST_OVERFLOW;
               end else begin
                  wr_en       = 1'b1;
                  wr_data     = alu_res;
                  opnd_cnt_in = opnd_cnt_ff + 1'b1;
               end
               state_in = S_WAIT;
            end
         end

         // restoring divide, one quotient bit per cycle
         S_DIV: begin
            rem_in  = ge ? W'(shifted - {1'b0, dvs_ff}) : shifted[W-1:0];
            quo_in  = {quo_ff[W-2:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == iie_pkg::DIV_CNT_WIDTH'(W - 1)) state_in = S_DIVEND;
         end

         S_DIVEND: begin
            if (opnd_full) begin
               err_in = iie_pkg::ST_OVERFLOW;
            end else begin
               wr_en       = 1'b1;
               wr_data     = div_res;
               opnd_cnt_in = opnd_cnt_ff + 1'b1;
            end
            state_in = S_WAIT;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_END;
         last_ff      <= 1'b0;
         acc_ff       <= '0;
         in_num_ff    <= 1'b0;
         err_ff       <= iie_pkg::ST_OK;
         opnd_cnt_ff  <= '0;
         oper_cnt_ff  <= '0;
         dcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         last_ff      <= last_in;
         acc_ff       <= acc_in;
         in_num_ff    <= in_num_in;
         err_ff       <= err_in;
         opnd_cnt_ff  <= opnd_cnt_in;
         oper_cnt_ff  <= oper_cnt_in;
         dcnt_ff      <= dcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff  <= pend_in;
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      out_ff   <= out_in;
   end

   // operand stack memory, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) opnd_mem[wr_addr] <= wr_data;
      rd_top_ff <= opnd_mem[opnd_m1[IW-1:0]];
      rd_sub_ff <= opnd_mem[opnd_m2[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (op_wr_en) oper_stk_ff[op_wr_addr] <= op_wr_data;
   end

endmodule

`default_nettype wire

>>> rtl/core/integer_infix_expression_evaluator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer infix expression evaluator. Push one ASCII character per request
// (req_data.char_code) and mark the final one with req_data.last; one result
// (32-bit wrapping value and a 2-bit status) then appears on rsp_data. Digits
// build numbers, + - * / % ( ) are operators, all else is skipped; * / % bind
// tighter than + -, equal levels go left to right, / and % truncate toward
// zero. Any error (divide by zero, unbalanced parentheses, stack overflow)
// gives value 0. A digit, an opening parenthesis or a skipped character is
// taken in the executor's idle state; an operator or closing parenthesis
// first reduces stacked operators as precedence or parentheses require,
// each divide or modulo going through the bit-serial divider. The final
// character also reduces every operator still stacked, then loads the
// result. The classifier feeds a 4-entry token queue, so requests keep
// flowing while the executor works until the queue fills; the result
// sits in a one-entry output register until popped.
module integer_infix_expression_evaluator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  iie_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output iie_pkg::rsp_type rsp_data
);

   iie_pkg::token_type       front_tok;
   iie_pkg::token_type       q_tok;
   logic                     q_empty;
   logic                     q_pop;
   iie_pkg::back_status_type bstat;

   // classify each character into a token
   iie_front u_front (
      .req_in  (req_data),
      .tok_out (front_tok)
   );

   // decouples request side from the executor
   iie_tokq u_tokq (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_tok),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_tok),
      .empty     (q_empty)
   );

   // stack machine and divider
   iie_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (q_tok),
      .tok_empty (q_empty),
      .tok_pop   (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .status    (bstat)
   );

`ifndef SYNTH
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      bstat.opnd_cnt <= iie_pkg::CNT_WIDTH'(iie_pkg::STACK_DEPTH) &&
      bstat.oper_cnt <= iie_pkg::CNT_WIDTH'(iie_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != iie_pkg::ST_OK) |-> rsp_data.value == 0)
      else $error("error result with nonzero value");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");
`endif

endmodule

`default_nettype wire
